>>> sv/bmpq_pkg.sv
// bmpq_pkg: shared types and constants of the bounded min priority queue
// used by bmpq_ctrl, bmpq_dp and bounded_min_priority_queue_core
`timescale 1ns / 1ps

package bmpq_pkg;

  localparam int unsigned MODE_W    = 2;
  localparam int unsigned PAYLOAD_W = 32;
  localparam int unsigned PRIO_W    = 16;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned CAP_W     = 5;
  localparam int unsigned COUNT_W   = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  // request codes, the unused code behaves as peek
  localparam logic [MODE_W-1:0] MODE_ENQ  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DEQ  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PEEK = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0]        mode;
    logic [PAYLOAD_W-1:0]     payload;
    logic signed [PRIO_W-1:0] priority_req;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic [PAYLOAD_W-1:0]     out_payload;
    logic signed [PRIO_W-1:0] out_priority;
    logic [COUNT_W-1:0]       entry_count;
    logic                     is_empty;
    logic                     is_full;
  } out_item_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic exec;
  } dp_cmd_t;

endpackage

>>> sv/bounded_min_priority_queue_core.sv
// bounded min priority queue: one transfer in, one result transfer out per request
// the result is registered by the execute step that follows the input transfer
// the controller takes a new request only in its load step, after the execute step of the last one
// a full result register stalls the execute step until its transfer completes
// reset: queue empty, capacity 16, no result pending
// depends on bmpq_pkg, bmpq_ctrl, bmpq_dp
`timescale 1ns / 1ps

module bounded_min_priority_queue_core #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [bmpq_pkg::CAP_W-1:0] cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  bmpq_pkg::in_item_t         in_item_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output bmpq_pkg::out_item_t        out_item_o
);
  import bmpq_pkg::*;

  logic [CAP_W-1:0] cap_q;
  dp_cmd_t          cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  bmpq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .cmd_o      (cmd)
  );

  bmpq_dp #(
    .DEPTH(DEPTH)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .in_item_i (in_item_i),
    .cap_i     (cap_q),
    .out_item_o(out_item_o)
  );

endmodule

>>> sv/bmpq_ctrl.sv
// bmpq_ctrl: sequencer of the priority queue, handshakes and datapath commands
// depends on bmpq_pkg
`timescale 1ns / 1ps

module bmpq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output bmpq_pkg::dp_cmd_t cmd_o
);
  import bmpq_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  assign cmd_o.load = (state_q == ST_IDLE) && in_valid_i;
  assign cmd_o.exec = (state_q == ST_EXEC) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (out_valid_q && !out_stall_i) begin
            out_valid_q <= 1'b0;
          end
          if (in_valid_i) begin
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          // wait until the result register is free
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> sv/bmpq_dp.sv
// bmpq_dp: sorted entry register chain, request register and result register
// depends on bmpq_pkg
`timescale 1ns / 1ps

module bmpq_dp #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  bmpq_pkg::dp_cmd_t              cmd_i,
  input  bmpq_pkg::in_item_t             in_item_i,
  input  logic [bmpq_pkg::CAP_W-1:0]     cap_i,
  output bmpq_pkg::out_item_t            out_item_o
);
  import bmpq_pkg::*;

  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = (CW > CAP_W) ? CW : CAP_W;
  localparam logic [CMPW-1:0] DEPTH_C = CMPW'(DEPTH);

  // entries kept sorted by priority, equal priorities in insertion order
  logic signed [PRIO_W-1:0]    prio_q [DEPTH];
  logic        [PAYLOAD_W-1:0] pay_q  [DEPTH];
  logic        [CW-1:0]        count_q;
  logic        [CW-1:0]        count_d;
  in_item_t                    req_q;
  out_item_t                   res_q;
  out_item_t                   res_d;

  logic [DEPTH-1:0] after;
  logic [CMPW-1:0]  cap_ext;
  logic [CMPW-1:0]  cap_eff;
  logic [CMPW-1:0]  count_ext;
  logic [CMPW-1:0]  count_next_ext;
  logic             is_enq;
  logic             is_deq;
  logic             empty;
  logic             full_now;
  logic             enq_ok;
  logic             deq_ok;

  assign cap_ext   = CMPW'(cap_i);
  assign cap_eff   = (cap_ext > DEPTH_C) ? DEPTH_C : cap_ext;
  assign count_ext = CMPW'(count_q);

  assign is_enq   = (req_q.mode == MODE_ENQ);
  assign is_deq   = (req_q.mode == MODE_DEQ);
  assign empty    = (count_q == '0);
  assign full_now = (count_ext >= cap_eff);
  assign enq_ok   = is_enq && !full_now;
  assign deq_ok   = is_deq && !empty;

  always_comb begin
    priority if (enq_ok) begin
      count_d = count_q + CW'(1);
    end else if (deq_ok) begin
      count_d = count_q - CW'(1);
    end else begin
      count_d = count_q;
    end
  end

  assign count_next_ext = CMPW'(count_d);

  always_comb begin
    res_d = '0;
    if (is_enq) begin
      res_d.status = full_now ? STATUS_FULL : STATUS_DONE;
    end else if (empty) begin
      res_d.status = STATUS_EMPTY;
    end else begin
      res_d.status       = STATUS_DONE;
      res_d.out_payload  = pay_q[0];
      res_d.out_priority = prio_q[0];
    end
    res_d.entry_count = count_next_ext[COUNT_W-1:0];
    res_d.is_empty    = (count_d == '0);
    res_d.is_full     = (count_next_ext >= cap_eff);
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_slot
    logic signed [PRIO_W-1:0]    prio_d;
    logic        [PAYLOAD_W-1:0] pay_d;

    assign after[i] = (CW'(i) < count_q) && (prio_q[i] <= req_q.priority_req);

    always_comb begin
      prio_d = prio_q[i];
      pay_d  = pay_q[i];
      if (is_enq) begin
        if (!after[i]) begin
          if (i == 0) begin
            prio_d = req_q.priority_req;
            pay_d  = req_q.payload;
          end else if (after[(i == 0) ? 0 : i - 1]) begin
            prio_d = req_q.priority_req;
            pay_d  = req_q.payload;
          end else begin
            prio_d = prio_q[(i == 0) ? 0 : i - 1];
            pay_d  = pay_q[(i == 0) ? 0 : i - 1];
          end
        end
      end else if (i < DEPTH - 1) begin
        // dequeue pulls the chain one slot toward the head
        prio_d = prio_q[(i < DEPTH - 1) ? i + 1 : i];
        pay_d  = pay_q[(i < DEPTH - 1) ? i + 1 : i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.exec && (enq_ok || deq_ok)) begin
        prio_q[i] <= prio_d;
        pay_q[i]  <= pay_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.exec) begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= in_item_i;
    end
    if (cmd_i.exec) begin
      res_q <= res_d;
    end
  end

  assign out_item_o = res_q;

endmodule
